>>> src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, widths and codes for the paired sample covariance block.
// ----------------------------------------------------------------------------
package psc_pkg;

    // Set and sample limits
    localparam int MAX_PAIRS = 65536;
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 8;

    // Derived widths
    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int PROD_W = 2 * SAMPLE_W + CNT_W - 1;
    localparam int ACC_W  = 2 * SAMPLE_W + 2 * CNT_W - 1;
    localparam int MAG_W  = ACC_W - 1;
    localparam int DIV_W  = MAG_W + FRAC_BITS;
    localparam int STEP_W = $clog2(DIV_W);

    // Result field widths
    localparam int MEAN_W = 24;
    localparam int VAR_W  = 39;
    localparam int COV_W  = 40;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_sample;
        logic signed [SAMPLE_W-1:0] y_sample;
        logic                       last_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_x;
        logic signed [MEAN_W-1:0] mean_y;
        logic        [VAR_W-1:0]  var_x;
        logic signed [COV_W-1:0]  cov_xy;
        logic        [VAR_W-1:0]  var_y;
        logic        [CNT_W-1:0]  pair_count;
    } t_out_word;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_MUL_N,
        S_SWAP,
        S_MUL_S,
        S_MAG,
        S_DIV1,
        S_REDIV,
        S_DIV2,
        S_STORE,
        S_OUT
    } t_state;

    // Statistic being worked on
    typedef enum logic [2:0] {
        JOB_MEAN_X,
        JOB_MEAN_Y,
        JOB_VAR_X,
        JOB_COV,
        JOB_VAR_Y
    } t_job;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCUM,
        OP_SETUP,
        OP_MUL_STEP,
        OP_MUL_SWAP,
        OP_MAG,
        OP_DIV_STEP,
        OP_DIV_RESTART,
        OP_STORE,
        OP_LOAD_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        t_job job;
    } t_dp_cmd;

    typedef struct packed {
        logic closes;
        logic out_free;
    } t_dp_status;

endpackage

>>> src/paired_sample_covariance.sv
// ----------------------------------------------------------------------------
// paired_sample_covariance
// Population means, variances and covariance of a set of (x, y) pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per
//   cycle: a signed x and y sample and a flag on the final pair of a set.
//   A set also closes on its own when it reaches MAX_PAIRS pairs.
//   Sums of x, y, x*x, x*y and y*y are kept exactly as the words arrive.
//   When a set closes, input stalls while a shift-add multiplier (one bit
//   per cycle) forms n*Sab - Sa*Sb for a variance or the covariance and a
//   restoring divider (one quotient bit per cycle, run once for a mean and
//   twice for the division by n squared) produces each statistic in turn:
//   mean x, mean y, var x, cov and var y; then the result register is loaded.
//   Output channel (o_out_valid / i_out_ready / o_out_word) carries one word
//   per set from a holding register, so a new set streams in while a result
//   waits. If the receiver still holds the previous result when the next
//   one is ready, the sequencer waits and input stays stalled.
//   Reset clears the sums and drops any pending result.
// ----------------------------------------------------------------------------
module paired_sample_covariance
    import psc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer: owns the input handshake and issues datapath operations
    psc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: sums, multiplier, divider and the result register
    psc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_ready (i_out_ready)
    );

    // A closing word stops intake until the set's result is loaded
    a_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && w_status.closes) |=> !o_in_ready)
        else $error("input still open after a set closed");

    // Never overwrite a result the receiver has not taken
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_LOAD_OUT) |-> w_status.out_free)
        else $error("result register overwritten while full");

    // Every result covers at least one pair
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.pair_count != '0))
        else $error("result with empty pair count");

    // Accumulate only on an accepted word
    a_accum_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_ACCUM) |-> (i_in_valid && o_in_ready))
        else $error("sums changed without an accepted word");

endmodule

>>> src/psc_ctrl.sv
// ----------------------------------------------------------------------------
// psc_ctrl
// Sequencer: accepts words, then walks the five statistics through the
// shared multiply (second moments only) and divide steps of the datapath.
// ----------------------------------------------------------------------------
module psc_ctrl
    import psc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state            r_state, n_state;
    t_job              r_job,   n_job;
    logic [STEP_W-1:0] r_step,  n_step;

    logic w_is_mean;
    assign w_is_mean = (r_job == JOB_MEAN_X) || (r_job == JOB_MEAN_Y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= JOB_MEAN_X;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            r_step  <= n_step;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_step  = r_step + STEP_W'(1);
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_in_valid && i_status.closes) begin
                    n_state = S_SETUP;
                    n_job   = JOB_MEAN_X;
                end
            end
            S_SETUP: begin
                n_step  = '0;
                n_state = w_is_mean ? S_DIV1 : S_MUL_N;
            end
            S_MUL_N: begin
                if (r_step == STEP_W'(CNT_W - 1)) begin
                    n_state = S_SWAP;
                end
            end
            S_SWAP: begin
                n_step  = '0;
                n_state = S_MUL_S;
            end
            S_MUL_S: begin
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                n_step  = '0;
                n_state = S_DIV1;
            end
            S_DIV1: begin
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    n_state = w_is_mean ? S_STORE : S_REDIV;
                end
            end
            S_REDIV: begin
                n_step  = '0;
                n_state = S_DIV2;
            end
            S_DIV2: begin
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                n_step = '0;
                unique case (r_job)
                    JOB_MEAN_X: begin n_job = JOB_MEAN_Y; n_state = S_SETUP; end
                    JOB_MEAN_Y: begin n_job = JOB_VAR_X;  n_state = S_SETUP; end
                    JOB_VAR_X:  begin n_job = JOB_COV;    n_state = S_SETUP; end
                    JOB_COV:    begin n_job = JOB_VAR_Y;  n_state = S_SETUP; end
                    JOB_VAR_Y:  begin n_state = S_OUT; end
                    default:    begin n_state = S_OUT; end
                endcase
            end
            S_OUT: begin
                n_step = '0;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.job  = r_job;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.op   = i_in_valid ? OP_ACCUM : OP_NONE;
            end
            S_SETUP:  o_cmd.op = OP_SETUP;
            S_MUL_N:  o_cmd.op = OP_MUL_STEP;
            S_SWAP:   o_cmd.op = OP_MUL_SWAP;
            S_MUL_S:  o_cmd.op = OP_MUL_STEP;
            S_MAG:    o_cmd.op = OP_MAG;
            S_DIV1:   o_cmd.op = OP_DIV_STEP;
            S_REDIV:  o_cmd.op = OP_DIV_RESTART;
            S_DIV2:   o_cmd.op = OP_DIV_STEP;
            S_STORE:  o_cmd.op = OP_STORE;
            S_OUT:    o_cmd.op = i_status.out_free ? OP_LOAD_OUT : OP_NONE;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> src/psc_datapath.sv
// ----------------------------------------------------------------------------
// psc_datapath
// Running sums, a shift-add multiplier, a restoring divider and the
// output register, all driven by the sequencer's commands.
// ----------------------------------------------------------------------------
module psc_datapath
    import psc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_word   i_in_word,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_word  o_out_word,
    input  logic       i_out_ready
);

    // Running sums
    logic        [CNT_W-1:0]  r_count;
    logic signed [SUM_W-1:0]  r_sum_x, r_sum_y;
    logic signed [PROD_W-1:0] r_sum_xx, r_sum_xy, r_sum_yy;

    // Multiply / divide working registers
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_mcand;
    logic        [SUM_W-1:0]  r_mplier;
    logic                     r_sub;
    logic        [DIV_W-1:0]  r_num;
    logic        [CNT_W-1:0]  r_rem;
    logic                     r_neg;

    // Finished statistics
    logic signed [MEAN_W-1:0] r_mean_x, r_mean_y;
    logic        [VAR_W-1:0]  r_var_x, r_var_y;
    logic signed [COV_W-1:0]  r_cov_xy;

    t_out_word                r_out;
    logic                     r_out_valid;

    // Input products
    logic signed [2*SAMPLE_W-1:0] w_xx, w_xy, w_yy;
    logic        [CNT_W-1:0]      w_count_inc;

    assign w_xx = i_in_word.x_sample * i_in_word.x_sample;
    assign w_xy = i_in_word.x_sample * i_in_word.y_sample;
    assign w_yy = i_in_word.y_sample * i_in_word.y_sample;
    assign w_count_inc = r_count + CNT_W'(1);

    assign o_status.closes   = i_in_word.last_sample || (w_count_inc == CNT_W'(MAX_PAIRS));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Operand selection by statistic
    logic signed [SUM_W-1:0]  w_sa, w_sb;
    logic signed [PROD_W-1:0] w_sab;
    logic        [SUM_W-1:0]  w_abs_sa, w_abs_sb;

    always_comb begin
        w_sa  = r_sum_y;
        w_sb  = r_sum_y;
        w_sab = r_sum_yy;
        if ((i_cmd.job == JOB_MEAN_X) || (i_cmd.job == JOB_VAR_X)) begin
            w_sa  = r_sum_x;
            w_sb  = r_sum_x;
            w_sab = r_sum_xx;
        end else if (i_cmd.job == JOB_COV) begin
            w_sa  = r_sum_x;
            w_sab = r_sum_xy;
        end
    end

    assign w_abs_sa = w_sa[SUM_W-1] ? SUM_W'(-w_sa) : SUM_W'(w_sa);
    assign w_abs_sb = w_sb[SUM_W-1] ? SUM_W'(-w_sb) : SUM_W'(w_sb);

    // Magnitude of the moment numerator
    logic [ACC_W-1:0] w_acc_abs;
    assign w_acc_abs = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    // One restoring divide step
    logic [CNT_W:0] w_rem_sh, w_n_ext, w_diff;
    logic           w_qbit;

    assign w_rem_sh = {r_rem, r_num[DIV_W-1]};
    assign w_n_ext  = {1'b0, r_count};
    assign w_diff   = w_rem_sh - w_n_ext;
    assign w_qbit   = (w_rem_sh >= w_n_ext);

    // Signed quotient
    logic [DIV_W-1:0] w_q_signed;
    assign w_q_signed = r_neg ? (~r_num + DIV_W'(1)) : r_num;

    // Sums and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_xx    <= '0;
            r_sum_xy    <= '0;
            r_sum_yy    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_ACCUM) begin
                r_count  <= w_count_inc;
                r_sum_x  <= r_sum_x + SUM_W'(i_in_word.x_sample);
                r_sum_y  <= r_sum_y + SUM_W'(i_in_word.y_sample);
                r_sum_xx <= r_sum_xx + PROD_W'(w_xx);
                r_sum_xy <= r_sum_xy + PROD_W'(w_xy);
                r_sum_yy <= r_sum_yy + PROD_W'(w_yy);
            end else if (i_cmd.op == OP_LOAD_OUT) begin
                r_count  <= '0;
                r_sum_x  <= '0;
                r_sum_y  <= '0;
                r_sum_xx <= '0;
                r_sum_xy <= '0;
                r_sum_yy <= '0;
            end
            if (i_cmd.op == OP_LOAD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arithmetic working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_SETUP: begin
                r_acc    <= '0;
                r_mcand  <= ACC_W'(w_sab);
                r_mplier <= SUM_W'(r_count);
                r_sub    <= 1'b0;
                r_num    <= DIV_W'(w_abs_sa) << FRAC_BITS;
                r_rem    <= '0;
                r_neg    <= w_sa[SUM_W-1];
            end
            OP_MUL_STEP: begin
                if (r_mplier[0]) begin
                    r_acc <= r_sub ? (r_acc - r_mcand) : (r_acc + r_mcand);
                end
                r_mcand  <= r_mcand <<< 1;
                r_mplier <= r_mplier >> 1;
            end
            OP_MUL_SWAP: begin
                r_mcand  <= ACC_W'(w_sa);
                r_mplier <= w_abs_sb;
                r_sub    <= !w_sb[SUM_W-1];
            end
            OP_MAG: begin
                r_num <= DIV_W'(w_acc_abs[MAG_W-1:0]) << FRAC_BITS;
                r_neg <= r_acc[ACC_W-1];
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_num <= {r_num[DIV_W-2:0], w_qbit};
                r_rem <= w_qbit ? w_diff[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
            end
            OP_DIV_RESTART: begin
                r_rem <= '0;
            end
            OP_STORE: begin
                unique case (i_cmd.job)
                    JOB_MEAN_X: r_mean_x <= w_q_signed[MEAN_W-1:0];
                    JOB_MEAN_Y: r_mean_y <= w_q_signed[MEAN_W-1:0];
                    JOB_VAR_X:  r_var_x  <= w_q_signed[VAR_W-1:0];
                    JOB_COV:    r_cov_xy <= w_q_signed[COV_W-1:0];
                    JOB_VAR_Y:  r_var_y  <= w_q_signed[VAR_W-1:0];
                    default:    r_var_y  <= r_var_y;
                endcase
            end
            OP_LOAD_OUT: begin
                r_out.mean_x     <= r_mean_x;
                r_out.mean_y     <= r_mean_y;
                r_out.var_x      <= r_var_x;
                r_out.cov_xy     <= r_cov_xy;
                r_out.var_y      <= r_var_y;
                r_out.pair_count <= r_count;
            end
            OP_NONE, OP_ACCUM: begin
                r_rem <= r_rem;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
